@@ sv/hsl2rgb_pkg.sv @@
// Package for the HSL to RGB converter: widths, fixed-point constants and sextant codes.
package hsl2rgb_pkg;

    // Field widths
    localparam int HUE_W  = 16;
    localparam int Q16_W  = 17;
    localparam int FRAC_W = 16;
    localparam int CH_W   = 8;

    // Q.32 channel values reach 2^32 inclusive, hence 33 bits
    localparam int VAL_W  = 33;

    // Q1.16 constants
    localparam logic [Q16_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [Q16_W-1:0] HALF_Q16 = 17'd32768;

    // Full-scale channel code
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Sextant of the hue circle, named after the channel ordering it produces
    typedef enum logic [2:0] {
        SEXT_R_TO_Y = 3'd0,
        SEXT_Y_TO_G = 3'd1,
        SEXT_G_TO_C = 3'd2,
        SEXT_C_TO_B = 3'd3,
        SEXT_B_TO_M = 3'd4,
        SEXT_M_TO_R = 3'd5
    } sext_t;

endpackage

@@ sv/hsl_in_if.sv @@
// Input channel interface: one HSL pixel per beat.
interface hsl_in_if
    import hsl2rgb_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [Q16_W-1:0]  saturation;
    logic [Q16_W-1:0]  lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

@@ sv/rgb_out_if.sv @@
// Output channel interface: one 8-bit RGB triple per beat.
interface rgb_out_if
    import hsl2rgb_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ sv/hsl2rgb_chan8.sv @@
// Channel quantiser: floor(value * 255) of a Q.32 value, saturated to 8 bits.
module hsl2rgb_chan8
    import hsl2rgb_pkg::*;
(
    input  logic [VAL_W-1:0] val,
    output logic [CH_W-1:0]  chan
);

    logic [VAL_W+7:0] scaled;
    logic [8:0]       whole;

    // value * 255 as (value << 8) - value
    always_comb
    begin
        scaled = {val, 8'b0} - {8'b0, val};
        whole  = scaled[VAL_W+7:32];
        if (whole > {1'b0, CH_MAX})
            chan = CH_MAX;
        else
            chan = whole[CH_W-1:0];
    end

endmodule

@@ sv/hsl_to_rgb_converter_top.sv @@
// HSL to RGB converter top level: five-stage pipeline from HSL pixel to RGB triple.
//
//   channel | modport          | beat
//   --------+------------------+--------------------------------------------
//   hsl     | hsl_in_if.sink   | hue[15:0], saturation[16:0], lightness[16:0]
//   rgb     | rgb_out_if.source| red[7:0], green[7:0], blue[7:0]
//
// One pixel per clock while rgb.ready does not stall the output stage.
// Stages: clamp and l*s product, peak/floor/span, span*fraction product,
// ramp and sextant select, channel quantise into the output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out under an output stall and nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears the stage valid bits only.
module hsl_to_rgb_converter_top
    import hsl2rgb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    hsl_in_if.sink   hsl,
    rgb_out_if.source rgb
);

    // Stage valid bits and the backward ready chain
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !vld5_reg || rgb.ready;
    assign rdy4 = !vld4_reg || rdy5;
    assign rdy3 = !vld3_reg || rdy4;
    assign rdy2 = !vld2_reg || rdy3;
    assign rdy1 = !vld1_reg || rdy2;
    assign hsl.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) vld1_reg <= hsl.valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) vld4_reg <= vld3_reg;
            if (rdy5) vld5_reg <= vld4_reg;
        end
    end

    // ---------------- stage 1: clamp, l*s, hue*6 ----------------
    logic [Q16_W-1:0]   l1_reg, l1_next;
    logic [Q16_W-1:0]   s1_reg, s1_next;
    logic [VAL_W-1:0]   ls1_reg, ls1_next;
    logic [2:0]         sext1_reg, sext1_next;
    logic [FRAC_W-1:0]  frac1_reg, frac1_next;
    logic [2*Q16_W-1:0] ls_full;
    logic [HUE_W+2:0]   h6;

    always_comb
    begin
        s1_next    = (hsl.saturation > ONE_Q16) ? ONE_Q16 : hsl.saturation;
        l1_next    = (hsl.lightness > ONE_Q16) ? ONE_Q16 : hsl.lightness;
        ls_full    = {{Q16_W{1'b0}}, l1_next} * {{Q16_W{1'b0}}, s1_next};
        ls1_next   = ls_full[VAL_W-1:0];
        h6         = {3'b0, hsl.hue} * (HUE_W+3)'(6);
        sext1_next = h6[HUE_W+2:HUE_W];
        frac1_next = h6[FRAC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            l1_reg    <= l1_next;
            s1_reg    <= s1_next;
            ls1_reg   <= ls1_next;
            sext1_reg <= sext1_next;
            frac1_reg <= frac1_next;
        end
    end

    // ---------------- stage 2: peak v, floor m, span v-m ----------------
    logic [VAL_W-1:0]  v2_reg, v2_next;
    logic [VAL_W-1:0]  m2_reg, m2_next;
    logic [VAL_W-1:0]  d2_reg, d2_next;
    logic [Q16_W-1:0]  l2_reg;
    logic [2:0]        sext2_reg;
    logic [FRAC_W-1:0] frac2_reg;
    logic              zero2_reg;
    logic [VAL_W:0]    lsh, ssh, ls_w, v_w, m_w, d_w;
    logic              low_half;

    always_comb
    begin
        lsh      = {1'b0, l1_reg, 16'b0};
        ssh      = {1'b0, s1_reg, 16'b0};
        ls_w     = {1'b0, ls1_reg};
        low_half = (l1_reg <= HALF_Q16);
        if (low_half)
        begin
            // v = l(1+s), m = l(1-s), v-m = 2ls
            v_w = lsh + ls_w;
            m_w = lsh - ls_w;
            d_w = {ls_w[VAL_W-1:0], 1'b0};
        end
        else
        begin
            // v = l+s-ls, m = l-s+ls, v-m = 2(s-ls)
            v_w = lsh + ssh - ls_w;
            m_w = lsh + ls_w - ssh;
            d_w = ssh - ls_w;
            d_w = {d_w[VAL_W-1:0], 1'b0};
        end
        v2_next = v_w[VAL_W-1:0];
        m2_next = m_w[VAL_W-1:0];
        d2_next = d_w[VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            v2_reg    <= v2_next;
            m2_reg    <= m2_next;
            d2_reg    <= d2_next;
            l2_reg    <= l1_reg;
            sext2_reg <= sext1_reg;
            frac2_reg <= frac1_reg;
            zero2_reg <= (v2_next == '0);
        end
    end

    // ---------------- stage 3: ramp offset (v-m)*f ----------------
    logic [VAL_W-1:0]        vsf3_reg;
    logic [VAL_W-1:0]        v3_reg, m3_reg;
    logic [Q16_W-1:0]        l3_reg;
    logic [2:0]              sext3_reg;
    logic                    zero3_reg;
    logic [VAL_W+FRAC_W-1:0] span_prod;

    assign span_prod = {{FRAC_W{1'b0}}, d2_reg} * {{VAL_W{1'b0}}, frac2_reg};

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            vsf3_reg  <= span_prod[VAL_W+FRAC_W-1:FRAC_W];
            v3_reg    <= v2_reg;
            m3_reg    <= m2_reg;
            l3_reg    <= l2_reg;
            sext3_reg <= sext2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // ---------------- stage 4: ramps and sextant routing ----------------
    logic [VAL_W-1:0] r4_reg, r4_next;
    logic [VAL_W-1:0] g4_reg, g4_next;
    logic [VAL_W-1:0] b4_reg, b4_next;
    logic [VAL_W-1:0] mid1, mid2, gray;

    always_comb
    begin
        mid1 = m3_reg + vsf3_reg;
        mid2 = v3_reg - vsf3_reg;
        gray = {l3_reg, 16'b0};
        case (sext_t'(sext3_reg))
            SEXT_R_TO_Y: begin r4_next = v3_reg; g4_next = mid1;   b4_next = m3_reg; end
            SEXT_Y_TO_G: begin r4_next = mid2;   g4_next = v3_reg; b4_next = m3_reg; end
            SEXT_G_TO_C: begin r4_next = m3_reg; g4_next = v3_reg; b4_next = mid1;   end
            SEXT_C_TO_B: begin r4_next = m3_reg; g4_next = mid2;   b4_next = v3_reg; end
            SEXT_B_TO_M: begin r4_next = mid1;   g4_next = m3_reg; b4_next = v3_reg; end
            default:     begin r4_next = v3_reg; g4_next = m3_reg; b4_next = mid2;   end
        endcase
        // zero peak: grey at the lightness
        if (zero3_reg)
        begin
            r4_next = gray;
            g4_next = gray;
            b4_next = gray;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            r4_reg <= r4_next;
            g4_reg <= g4_next;
            b4_reg <= b4_next;
        end
    end

    // ---------------- stage 5: quantise into the output register ----------------
    logic [CH_W-1:0] red_next, green_next, blue_next;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;

    hsl2rgb_chan8 u_chan_r (.val(r4_reg), .chan(red_next));
    hsl2rgb_chan8 u_chan_g (.val(g4_reg), .chan(green_next));
    hsl2rgb_chan8 u_chan_b (.val(b4_reg), .chan(blue_next));

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = vld5_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

`ifndef SYNTHESIS
    // an empty output register means the whole pipe can take a beat
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !vld5_reg |-> hsl.ready)
        else $error("input not ready with drained output stage");

    // a stalled middle stage keeps its beat
    a_stage4_held: assert property (@(posedge clk) disable iff (!rst_n)
        vld4_reg && !rdy5 |=> vld4_reg)
        else $error("stage 4 beat lost under stall");

    // the floor never exceeds the peak and the span matches them
    a_span_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        vld2_reg |-> (m2_reg <= v2_reg) && (d2_reg == v2_reg - m2_reg))
        else $error("peak, floor and span inconsistent");

    // the ramp offset stays within the span
    a_offset_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg |-> (vsf3_reg <= v3_reg - m3_reg))
        else $error("ramp offset exceeds span");
`endif

endmodule
